// ----- hw/rtl/joystick_velocity_ramp_macros.svh -----
// Assertion macros for the joystick velocity ramp checker.
// No dependencies; included by jvr_checker.sv.
`ifndef JOYSTICK_VELOCITY_RAMP_MACROS_SVH
`define JOYSTICK_VELOCITY_RAMP_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define JVR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define JVR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/jvr_pkg.sv -----
// Shared types and constants of the joystick velocity ramp.
// No dependencies.
package jvr_pkg;

  localparam int JVR_SAMPLE_BITS   = 16;
  localparam int JVR_VELOCITY_BITS = 24;
  localparam int JVR_COUNTER_BITS  = 16;
  localparam int JVR_FIFO_DEPTH    = 4;

  localparam int SPEED_W = 20;  // max and step registers
  localparam int THR_W   = 16;  // deadzone, timeout, snap
  localparam int OUT_W   = 24;  // command width on the output beat
  localparam int USER_W  = 3;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    REG_LIN_SPEED_CAP  = 3'd0,
    REG_ANG_SPEED_CAP  = 3'd1,
    REG_STRAIGHT_MODE  = 3'd2,
    REG_LINEAR_STEP    = 3'd3,
    REG_ANGULAR_STEP   = 3'd4,
    REG_DEADZONE       = 3'd5,
    REG_TIMEOUT_TICKS  = 3'd6,
    REG_SNAP_THRESHOLD = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [SPEED_W-1:0] lin_speed_cap;
    logic [SPEED_W-1:0] ang_speed_cap;
    logic               straight_mode;
    logic [SPEED_W-1:0] linear_step;
    logic [SPEED_W-1:0] angular_step;
    logic [THR_W-1:0]   deadzone;
    logic [THR_W-1:0]   timeout_ticks;
    logic [THR_W-1:0]   snap_threshold;
  } jvr_cfg_t;

  localparam jvr_cfg_t CFG_RESET = '{
    lin_speed_cap:  20'd13107,
    ang_speed_cap:  20'd65536,
    straight_mode:  1'b0,
    linear_step:    20'd218,
    angular_step:   20'd2840,
    deadzone:       16'd2294,
    timeout_ticks:  16'd30,
    snap_threshold: 16'd66
  };

  // Classification of one beat as it travels from front to back.
  typedef struct packed {
    op_t  opcode;
    logic deadman_held;
    logic axes_present;
  } jvr_ctl_t;

endpackage

// ----- hw/rtl/joystick_velocity_ramp.sv -----
// Joystick velocity ramp, top level.
// Depends on jvr_pkg, jvr_regs, jvr_front, jvr_fifo and jvr_back.
//
// Usage
//   in_*  : one beat per joystick sample or control tick (in_tuser[0] is the
//           opcode: 0 sample, 1 tick). Samples update the velocity targets
//           and produce nothing; every tick produces exactly one out_* beat
//           with the ramped linear and angular commands.
//   cfg_* : APB-style register port, registers at byte address 4*index,
//           pready always high. Write only while the block is idle.
//   Throughput: one beat per cycle on in_*, sustained, as long as out_* is
//   drained. A tick accepted on in_* passes the multiply stage, the queue
//   and the output register, in that order, before it shows on out_*.
//   Each tick's ramp reads the currents left by the previous tick, a loop
//   closed inside the back end, which sets the one-beat-per-cycle rate.
//   Reset (rst_n low, synchronous) restores the register defaults, zeroes
//   targets, currents and the watchdog count, and empties the queue.
//   When out_tready is low, the result is held; samples keep draining from
//   the queue, ticks wait behind it, and in_tready drops once the
//   four-entry queue and the multiply stage are full.
module joystick_velocity_ramp #(
  parameter int SAMPLE_BITS   = jvr_pkg::JVR_SAMPLE_BITS,
  parameter int VELOCITY_BITS = jvr_pkg::JVR_VELOCITY_BITS,
  parameter int COUNTER_BITS  = jvr_pkg::JVR_COUNTER_BITS,
  parameter int FIFO_DEPTH    = jvr_pkg::JVR_FIFO_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [SAMPLE_BITS-1:0] raw_linear, [2*SAMPLE_BITS-1:SAMPLE_BITS] raw_angular
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] in_tdata,
  // [0] opcode, [1] deadman_held, [2] axes_present
  input  logic [jvr_pkg::USER_W-1:0]        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [23:0] linear_command, [47:24] angular_command
  output logic [2*jvr_pkg::OUT_W-1:0]       out_tdata,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [jvr_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [jvr_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [jvr_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);
  import jvr_pkg::*;

  localparam int V      = VELOCITY_BITS;
  localparam int CTL_W  = $bits(jvr_ctl_t);
  localparam int ENTRY_W = CTL_W + 2 * V;

  jvr_cfg_t            cfg;
  jvr_ctl_t            in_ctl, push_ctl, head_ctl;
  logic                push, pop, fifo_full, fifo_empty;
  logic signed [V-1:0] push_lin_tgt, push_ang_tgt;
  logic [ENTRY_W-1:0]  head;
  logic [OUT_W-1:0]    out_linear, out_angular;

  assign in_ctl.opcode       = op_t'(in_tuser[0]);
  assign in_ctl.deadman_held = in_tuser[1];
  assign in_ctl.axes_present = in_tuser[2];

  jvr_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  jvr_front #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .VELOCITY_BITS (VELOCITY_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_ctl       (in_ctl),
    .raw_linear   (in_tdata[SAMPLE_BITS-1:0]),
    .raw_angular  (in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .push         (push),
    .fifo_full    (fifo_full),
    .push_ctl     (push_ctl),
    .push_lin_tgt (push_lin_tgt),
    .push_ang_tgt (push_ang_tgt)
  );

  jvr_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_ang_tgt, push_lin_tgt, push_ctl}),
    .full      (fifo_full),
    .pop       (pop),
    .head      (head),
    .empty     (fifo_empty)
  );

  assign head_ctl = jvr_ctl_t'(head[CTL_W-1:0]);

  jvr_back #(
    .VELOCITY_BITS (VELOCITY_BITS),
    .COUNTER_BITS  (COUNTER_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .fifo_empty   (fifo_empty),
    .head_ctl     (head_ctl),
    .head_lin_tgt (head[CTL_W +: V]),
    .head_ang_tgt (head[CTL_W + V +: V]),
    .pop          (pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_linear   (out_linear),
    .out_angular  (out_angular)
  );

  assign out_tdata = {out_angular, out_linear};

endmodule

// ----- hw/rtl/jvr_regs.sv -----
// APB-style configuration register file.
// Depends on jvr_pkg.
module jvr_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [jvr_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [jvr_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [jvr_pkg::CFG_DATA_W-1:0] prdata,
  output logic                          pready,
  output jvr_pkg::jvr_cfg_t             cfg
);
  import jvr_pkg::*;

  jvr_cfg_t cfg_r, cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_LIN_SPEED_CAP:  cfg_nxt.lin_speed_cap  = pwdata[SPEED_W-1:0];
        REG_ANG_SPEED_CAP:  cfg_nxt.ang_speed_cap  = pwdata[SPEED_W-1:0];
        REG_STRAIGHT_MODE:  cfg_nxt.straight_mode  = pwdata[0];
        REG_LINEAR_STEP:    cfg_nxt.linear_step    = pwdata[SPEED_W-1:0];
        REG_ANGULAR_STEP:   cfg_nxt.angular_step   = pwdata[SPEED_W-1:0];
        REG_DEADZONE:       cfg_nxt.deadzone       = pwdata[THR_W-1:0];
        REG_TIMEOUT_TICKS:  cfg_nxt.timeout_ticks  = pwdata[THR_W-1:0];
        REG_SNAP_THRESHOLD: cfg_nxt.snap_threshold = pwdata[THR_W-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_LIN_SPEED_CAP:  prdata = CFG_DATA_W'(cfg_r.lin_speed_cap);
      REG_ANG_SPEED_CAP:  prdata = CFG_DATA_W'(cfg_r.ang_speed_cap);
      REG_STRAIGHT_MODE:  prdata = CFG_DATA_W'(cfg_r.straight_mode);
      REG_LINEAR_STEP:    prdata = CFG_DATA_W'(cfg_r.linear_step);
      REG_ANGULAR_STEP:   prdata = CFG_DATA_W'(cfg_r.angular_step);
      REG_DEADZONE:       prdata = CFG_DATA_W'(cfg_r.deadzone);
      REG_TIMEOUT_TICKS:  prdata = CFG_DATA_W'(cfg_r.timeout_ticks);
      REG_SNAP_THRESHOLD: prdata = CFG_DATA_W'(cfg_r.snap_threshold);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- hw/rtl/jvr_front.sv -----
// Front end: accepts beats, applies deadzone and scales axes into targets.
// Depends on jvr_pkg. Feeds jvr_fifo.
module jvr_front #(
  parameter int SAMPLE_BITS   = jvr_pkg::JVR_SAMPLE_BITS,
  parameter int VELOCITY_BITS = jvr_pkg::JVR_VELOCITY_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  jvr_pkg::jvr_cfg_t               cfg,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  jvr_pkg::jvr_ctl_t               in_ctl,
  input  logic signed [SAMPLE_BITS-1:0]   raw_linear,
  input  logic signed [SAMPLE_BITS-1:0]   raw_angular,
  output logic                            push,
  input  logic                            fifo_full,
  output jvr_pkg::jvr_ctl_t               push_ctl,
  output logic signed [VELOCITY_BITS-1:0] push_lin_tgt,
  output logic signed [VELOCITY_BITS-1:0] push_ang_tgt
);
  import jvr_pkg::*;

  localparam int PW  = SAMPLE_BITS + SPEED_W;           // product
  localparam int RW  = PW + 1 - (SAMPLE_BITS - 1);      // rounded, shifted
  localparam int WW  = ((VELOCITY_BITS > RW) ? VELOCITY_BITS : RW) + 1;
  localparam int DZW = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
  localparam logic [63:0] HI64 = (64'd1 << (VELOCITY_BITS - 1)) - 64'd1;
  localparam logic signed [WW-1:0] SAT_HI = WW'(HI64);
  localparam logic signed [WW-1:0] SAT_LO = -SAT_HI - WW'(1);
  localparam logic [PW:0] HALF = (PW + 1)'(64'd1 << (SAMPLE_BITS - 2));

  logic                   s1_valid_r, s1_valid_nxt;
  jvr_ctl_t               s1_ctl_r;
  logic [PW-1:0]          s1_lin_prod_r, s1_ang_prod_r;
  logic                   s1_lin_neg_r, s1_ang_neg_r;
  logic                   s1_lin_zero_r, s1_ang_zero_r;

  logic [SAMPLE_BITS-1:0] lin_mag, ang_mag;
  logic                   lin_dz, ang_dz;
  logic                   accept;

  function automatic logic [SAMPLE_BITS-1:0] mag_s(input logic signed [SAMPLE_BITS-1:0] a);
    return a[SAMPLE_BITS-1] ? SAMPLE_BITS'(-a) : SAMPLE_BITS'(a);
  endfunction

  // Round half away from zero on the magnitude, restore sign, saturate.
  function automatic logic signed [VELOCITY_BITS-1:0] finish(
    input logic [PW-1:0] prod, input logic neg, input logic zero);
    logic [PW:0]           rnd;
    logic [RW-1:0]         p;
    logic signed [WW-1:0]  v;
    logic signed [VELOCITY_BITS-1:0] r;
    rnd = (PW + 1)'(prod) + HALF;
    p   = rnd[PW -: RW];
    v   = neg ? -$signed(WW'(p)) : $signed(WW'(p));
    if (zero)            r = '0;
    else if (v > SAT_HI) r = VELOCITY_BITS'(SAT_HI);
    else if (v < SAT_LO) r = VELOCITY_BITS'(SAT_LO);
    else                 r = VELOCITY_BITS'(v);
    return r;
  endfunction

  assign lin_mag  = mag_s(raw_linear);
  assign ang_mag  = mag_s(raw_angular);
  assign lin_dz   = DZW'(lin_mag) < DZW'(cfg.deadzone);
  assign ang_dz   = DZW'(ang_mag) < DZW'(cfg.deadzone);

  assign in_ready = !s1_valid_r || !fifo_full;
  assign accept   = in_valid && in_ready;
  assign push     = s1_valid_r && !fifo_full;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept)    s1_valid_nxt = 1'b1;
    else if (push) s1_valid_nxt = 1'b0;
  end

  assign push_ctl     = s1_ctl_r;
  assign push_lin_tgt = finish(s1_lin_prod_r, s1_lin_neg_r, s1_lin_zero_r);
  assign push_ang_tgt = finish(s1_ang_prod_r, s1_ang_neg_r, s1_ang_zero_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctl_r      <= in_ctl;
      s1_lin_prod_r <= PW'(lin_mag) * PW'(cfg.lin_speed_cap);
      s1_ang_prod_r <= PW'(ang_mag) * PW'(cfg.ang_speed_cap);
      s1_lin_neg_r  <= raw_linear[SAMPLE_BITS-1];
      s1_ang_neg_r  <= raw_angular[SAMPLE_BITS-1];
      s1_lin_zero_r <= lin_dz;
      s1_ang_zero_r <= ang_dz || cfg.straight_mode;
    end
  end

endmodule

// ----- hw/rtl/jvr_fifo.sv -----
// Short register queue between the front and back ends.
// Depends on jvr_pkg for the default depth.
module jvr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = jvr_pkg::JVR_FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = count_r == CNT_W'(DEPTH);
  assign empty   = count_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_comb begin
    wr_ptr_nxt = do_push ? bump(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? bump(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- hw/rtl/jvr_back.sv -----
// Back end: holds targets and currents, runs watchdog, ramp and snap on ticks.
// Depends on jvr_pkg. Drains jvr_fifo and owns the output register.
module jvr_back #(
  parameter int VELOCITY_BITS = jvr_pkg::JVR_VELOCITY_BITS,
  parameter int COUNTER_BITS  = jvr_pkg::JVR_COUNTER_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  jvr_pkg::jvr_cfg_t               cfg,
  input  logic                            fifo_empty,
  input  jvr_pkg::jvr_ctl_t               head_ctl,
  input  logic signed [VELOCITY_BITS-1:0] head_lin_tgt,
  input  logic signed [VELOCITY_BITS-1:0] head_ang_tgt,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [jvr_pkg::OUT_W-1:0]       out_linear,
  output logic [jvr_pkg::OUT_W-1:0]       out_angular
);
  import jvr_pkg::*;

  localparam int V   = VELOCITY_BITS;
  localparam int DW  = V + 1;
  localparam int CW  = ((DW > SPEED_W) ? DW : SPEED_W) + 1;
  localparam int SW  = ((V > SPEED_W) ? V : SPEED_W) + 2;
  localparam int MW  = (V > THR_W) ? V : THR_W;
  localparam int KW  = (COUNTER_BITS > THR_W) ? COUNTER_BITS : THR_W;

  logic signed [V-1:0]     lin_tgt_r, lin_tgt_nxt, ang_tgt_r, ang_tgt_nxt;
  logic signed [V-1:0]     lin_cur_r, lin_cur_nxt, ang_cur_r, ang_cur_nxt;
  logic [COUNTER_BITS-1:0] ticks_r, ticks_nxt, ticks_inc;
  logic                    out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]        out_lin_r, out_ang_r;

  logic signed [V-1:0]     t_lin_tgt, t_ang_tgt, r_lin, r_ang;
  logic                    fire, snap, do_tick;

  function automatic logic [V-1:0] mag_v(input logic signed [V-1:0] x);
    return x[V-1] ? V'(-x) : V'(x);
  endfunction

  function automatic logic signed [V-1:0] ramp(
    input logic signed [V-1:0] cur, input logic signed [V-1:0] tgt,
    input logic [SPEED_W-1:0] step);
    logic signed [DW-1:0] diff;
    logic [DW-1:0]        adiff;
    logic signed [SW-1:0] moved;
    diff  = DW'(tgt) - DW'(cur);
    adiff = diff[DW-1] ? DW'(-diff) : DW'(diff);
    moved = diff[DW-1] ? SW'(cur) - $signed(SW'(step)) : SW'(cur) + $signed(SW'(step));
    return (CW'(adiff) <= CW'(step)) ? tgt : V'(moved);
  endfunction

  assign ticks_inc = (&ticks_r) ? ticks_r : ticks_r + COUNTER_BITS'(1);
  assign fire      = KW'(ticks_inc) > KW'(cfg.timeout_ticks);
  assign t_lin_tgt = fire ? '0 : lin_tgt_r;
  assign t_ang_tgt = fire ? '0 : ang_tgt_r;
  assign r_lin     = ramp(lin_cur_r, t_lin_tgt, cfg.linear_step);
  assign r_ang     = ramp(ang_cur_r, t_ang_tgt, cfg.angular_step);
  assign snap      = (MW'(mag_v(r_lin))     < MW'(cfg.snap_threshold)) &&
                     (MW'(mag_v(r_ang))     < MW'(cfg.snap_threshold)) &&
                     (MW'(mag_v(t_lin_tgt)) < MW'(cfg.snap_threshold)) &&
                     (MW'(mag_v(t_ang_tgt)) < MW'(cfg.snap_threshold));

  // A sample never waits on the output side; a tick needs the output slot.
  assign pop     = !fifo_empty &&
                   ((head_ctl.opcode == OP_SAMPLE) || !out_valid_r || out_ready);
  assign do_tick = pop && (head_ctl.opcode == OP_TICK);

  always_comb begin
    lin_tgt_nxt   = lin_tgt_r;
    ang_tgt_nxt   = ang_tgt_r;
    lin_cur_nxt   = lin_cur_r;
    ang_cur_nxt   = ang_cur_r;
    ticks_nxt     = ticks_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (pop) begin
      unique case (head_ctl.opcode)
        OP_SAMPLE: begin
          ticks_nxt = '0;
          if (!head_ctl.deadman_held) begin
            lin_tgt_nxt = '0;
            ang_tgt_nxt = '0;
          end else if (head_ctl.axes_present) begin
            lin_tgt_nxt = head_lin_tgt;
            ang_tgt_nxt = head_ang_tgt;
          end
        end
        OP_TICK: begin
          ticks_nxt     = ticks_inc;
          lin_tgt_nxt   = t_lin_tgt;
          ang_tgt_nxt   = t_ang_tgt;
          lin_cur_nxt   = snap ? '0 : r_lin;
          ang_cur_nxt   = snap ? '0 : r_ang;
          out_valid_nxt = 1'b1;
        end
        default: ticks_nxt = ticks_r;
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_linear  = out_lin_r;
  assign out_angular = out_ang_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lin_tgt_r   <= '0;
      ang_tgt_r   <= '0;
      lin_cur_r   <= '0;
      ang_cur_r   <= '0;
      ticks_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      lin_tgt_r   <= lin_tgt_nxt;
      ang_tgt_r   <= ang_tgt_nxt;
      lin_cur_r   <= lin_cur_nxt;
      ang_cur_r   <= ang_cur_nxt;
      ticks_r     <= ticks_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_tick) begin
      out_lin_r <= OUT_W'(lin_cur_nxt);
      out_ang_r <= OUT_W'(ang_cur_nxt);
    end
  end

endmodule

// ----- hw/rtl/jvr_checker.sv -----
// Port-level checker for the joystick velocity ramp, bound to the top level.
// Depends on jvr_pkg and joystick_velocity_ramp_macros.svh.
`include "joystick_velocity_ramp_macros.svh"

module jvr_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [2*jvr_pkg::OUT_W-1:0]    out_tdata,
  input logic                           cfg_psel,
  input logic                           cfg_penable,
  input logic                           cfg_pwrite,
  input logic [jvr_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input logic [jvr_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  input logic [jvr_pkg::CFG_DATA_W-1:0] cfg_prdata,
  input logic                           cfg_pready
);
  import jvr_pkg::*;

  // A stalled result beat stays up with the same commands.
  `JVR_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "out beat dropped while stalled")
  `JVR_ASSERT_NEXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata), "out beat changed while stalled")

  // No register is wider than the speed fields.
  `JVR_ASSERT_SAME(a_prdata_upper, 1'b1, cfg_prdata[CFG_DATA_W-1:SPEED_W] == '0, "prdata upper bits set")

  // Straight-mode readback follows the last write.
  `JVR_ASSERT_NEXT(a_straight_rb, cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && (cfg_paddr[CFG_ADDR_W-1:2] == REG_STRAIGHT_MODE), !$stable(cfg_paddr) || ((cfg_prdata[0] == $past(cfg_pwdata[0])) && (cfg_prdata[CFG_DATA_W-1:1] == '0)), "straight mode readback mismatch")

endmodule

bind joystick_velocity_ramp jvr_checker u_jvr_checker (.*);

// ----- sim/tb_joystick_velocity_ramp.sv -----
// Self-checking testbench for joystick_velocity_ramp: random samples and ticks
// on the input stream, register phases over APB, commands checked per beat.
// Depends on jvr_pkg and the joystick_velocity_ramp RTL.
`timescale 1ns / 100ps

module tb_joystick_velocity_ramp;
  import jvr_pkg::*;

  localparam int     DRAIN_CYCLES = 16;
  localparam longint CYCLE_LIMIT  = 200_000;
  localparam longint VEL_HI       = 8388607;
  localparam longint VEL_LO       = -8388608;
  localparam int     PHASE_BEATS  = 160;
  localparam int     LONG_TICKS   = 80;

  typedef struct {
    op_t              op;
    bit               deadman;
    bit               axes;
    bit signed [15:0] raw_lin;
    bit signed [15:0] raw_ang;
  } joy_beat_t;

  typedef struct {
    bit signed [23:0] linear;
    bit signed [23:0] angular;
  } vel_cmd_t;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata    = '0;  // [15:0] raw_linear, [31:16] raw_angular
  logic [2:0]  in_tuser    = '0;  // [0] opcode, [1] deadman_held, [2] axes_present
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [47:0] out_tdata;         // [23:0] linear_command, [47:24] angular_command
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr  = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  joystick_velocity_ramp DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predictor state
  jvr_cfg_t         cfg_model = CFG_RESET;
  bit signed [23:0] lin_target, ang_target, lin_now, ang_now;
  bit [15:0]        idle_ticks;

  joy_beat_t beats_to_send[$];
  vel_cmd_t  cmds_expected[$];
  joy_beat_t driven_beat;
  int        errors     = 0;
  longint    cycles     = 0;
  int        burst_left = 0;
  int        gap_left   = 0;
  int        stall_mode = 0;
  int        stall_left = 0;

  function automatic longint mag(longint x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic longint scale_axis(bit signed [15:0] raw, bit [19:0] full_scale);
    longint a, m, p;
    a = longint'(raw);
    m = mag(a);
    if (m < longint'(cfg_model.deadzone)) return 0;
    p = (m * longint'(full_scale) + 16384) >>> 15;
    if (a < 0) p = -p;
    if (p > VEL_HI) p = VEL_HI;
    if (p < VEL_LO) p = VEL_LO;
    return p;
  endfunction

  function automatic longint step_toward(longint cur, longint tgt, longint step);
    longint diff;
    diff = tgt - cur;
    if (mag(diff) <= step) return tgt;
    return (diff > 0) ? cur + step : cur - step;
  endfunction

  function automatic void update_velocity(joy_beat_t b);
    longint   th, lc, ac;
    vel_cmd_t cmd;
    if (b.op == OP_SAMPLE) begin
      idle_ticks = '0;
      if (!b.deadman) begin
        lin_target = '0;
        ang_target = '0;
      end else if (b.axes) begin
        lin_target = 24'(scale_axis(b.raw_lin, cfg_model.lin_speed_cap));
        ang_target = cfg_model.straight_mode ? '0 :
                     24'(scale_axis(b.raw_ang, cfg_model.ang_speed_cap));
      end
      return;
    end
    if (idle_ticks != '1) idle_ticks++;
    if (idle_ticks > cfg_model.timeout_ticks) begin
      lin_target = '0;
      ang_target = '0;
    end
    lc = step_toward(longint'(lin_now), longint'(lin_target),
                     longint'(cfg_model.linear_step));
    ac = step_toward(longint'(ang_now), longint'(ang_target),
                     longint'(cfg_model.angular_step));
    th = longint'(cfg_model.snap_threshold);
    if (mag(lc) < th && mag(ac) < th && mag(longint'(lin_target)) < th &&
        mag(longint'(ang_target)) < th) begin
      lc = 0;
      ac = 0;
    end
    lin_now = 24'(lc);
    ang_now = 24'(ac);
    cmd.linear  = lc[23:0];
    cmd.angular = ac[23:0];
    cmds_expected.push_back(cmd);
  endfunction

  // Sender: bursts of random length, random gaps, sometimes long gapless runs
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) update_velocity(driven_beat);
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (beats_to_send.size() > 0) begin
          driven_beat = beats_to_send.pop_front();
          in_tdata  <= {driven_beat.raw_ang, driven_beat.raw_lin};
          in_tuser  <= {driven_beat.axes, driven_beat.deadman, driven_beat.op};
          in_tvalid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else if ($urandom_range(0, 4) == 0) begin
            burst_left = $urandom_range(100, 300);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(0, 12);
            gap_left   = $urandom_range(1, 6);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stretches of always-ready, coin-flip and mostly-stalled
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      2:       out_tready <= ($urandom_range(0, 1) == 1);
      3:       out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= 1'b1;
    endcase
  end

  always @(posedge clk) begin : cmd_check
    vel_cmd_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (cmds_expected.size() == 0) begin
        $display("%0t: command beat with none expected: %h", $time, out_tdata);
        errors++;
      end else begin
        want = cmds_expected.pop_front();
        if (out_tdata[23:0] !== want.linear) begin
          $display("%0t: linear_command expected %0d got %0d", $time, want.linear,
                   $signed(out_tdata[23:0]));
          errors++;
        end
        if (out_tdata[47:24] !== want.angular) begin
          $display("%0t: angular_command expected %0d got %0d", $time, want.angular,
                   $signed(out_tdata[47:24]));
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_joystick_velocity_ramp NOT OK");
      $finish;
    end
  end

  function automatic joy_beat_t make_beat(op_t op, bit dm, bit ax, int lin, int ang);
    joy_beat_t b;
    b.op      = op;
    b.deadman = dm;
    b.axes    = ax;
    b.raw_lin = lin[15:0];
    b.raw_ang = ang[15:0];
    return b;
  endfunction

  function automatic int rand_axis();
    int v;
    case ($urandom_range(0, 7))
      0: return -32768;
      1: return 32767;
      2: begin
        // straddle the deadzone edge
        v = int'(cfg_model.deadzone) + $urandom_range(0, 2) - 1;
        return ($urandom_range(0, 1) == 1) ? -v : v;
      end
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic joy_beat_t rand_tick();
    return make_beat(OP_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     $urandom_range(0, 65535), $urandom_range(0, 65535));
  endfunction

  task automatic queue_random(int n);
    int count, r, run;
    count = 0;
    while (count < n) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        beats_to_send.push_back(rand_tick());
        count++;
      end else if (r < 50) begin
        // long tick run to trip the watchdog
        run = $urandom_range(5, 45);
        repeat (run) beats_to_send.push_back(rand_tick());
        count += run;
      end else begin
        if (r < 85)
          beats_to_send.push_back(make_beat(OP_SAMPLE, 1'b1, 1'b1, rand_axis(), rand_axis()));
        else if (r < 92)
          beats_to_send.push_back(make_beat(OP_SAMPLE, 1'b0, 1'($urandom_range(0, 1)),
                                            rand_axis(), rand_axis()));
        else
          beats_to_send.push_back(make_beat(OP_SAMPLE, 1'b1, 1'b0, rand_axis(), rand_axis()));
        count++;
      end
    end
  endtask

  task automatic wait_quiet();
    do @(posedge clk);
    while (beats_to_send.size() != 0 || in_tvalid || cmds_expected.size() != 0);
    // samples leave no result, so let the pipeline empty
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, int unsigned value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_LIN_SPEED_CAP:  cfg_model.lin_speed_cap  = value[19:0];
      REG_ANG_SPEED_CAP:  cfg_model.ang_speed_cap  = value[19:0];
      REG_STRAIGHT_MODE:  cfg_model.straight_mode  = value[0];
      REG_LINEAR_STEP:    cfg_model.linear_step    = value[19:0];
      REG_ANGULAR_STEP:   cfg_model.angular_step   = value[19:0];
      REG_DEADZONE:       cfg_model.deadzone       = value[15:0];
      REG_TIMEOUT_TICKS:  cfg_model.timeout_ticks  = value[15:0];
      REG_SNAP_THRESHOLD: cfg_model.snap_threshold = value[15:0];
      default: ;
    endcase
  endtask

  function automatic int unsigned pick_value(int unsigned typ_lo, int unsigned typ_hi,
                                             int unsigned full_max);
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return full_max;
      2, 3:    return $urandom_range(0, full_max);
      default: return $urandom_range(typ_lo, typ_hi);
    endcase
  endfunction

  task automatic program_phase(int p);
    int unsigned vals[8];
    case (p)
      1: vals = '{20'hFFFFF, 20'hFFFFF, 0, 20'hFFFFF, 20'hFFFFF, 0, 16'hFFFF, 0};
      2: vals = '{0, 0, 1, 0, 0, 16'hFFFF, 0, 16'hFFFF};
      9: vals = '{65536, 65536, 0, 3000, 3000, 0, 16'hFFFF, 0};
      default: begin
        vals[REG_LIN_SPEED_CAP]  = pick_value(1000, 300000, 20'hFFFFF);
        vals[REG_ANG_SPEED_CAP]  = pick_value(1000, 300000, 20'hFFFFF);
        vals[REG_STRAIGHT_MODE]  = $urandom_range(0, 1);
        vals[REG_LINEAR_STEP]    = pick_value(1, 8000, 20'hFFFFF);
        vals[REG_ANGULAR_STEP]   = pick_value(1, 8000, 20'hFFFFF);
        vals[REG_DEADZONE]       = pick_value(0, 4000, 16'hFFFF);
        if ($urandom_range(0, 5) == 0) vals[REG_DEADZONE] = 32767 + $urandom_range(0, 2);
        vals[REG_TIMEOUT_TICKS]  = pick_value(1, 40, 16'hFFFF);
        vals[REG_SNAP_THRESHOLD] = pick_value(0, 2000, 16'hFFFF);
      end
    endcase
    for (int i = 0; i < 8; i++) write_reg(reg_idx_t'(i), vals[i]);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: full deflection, axes missing, deadman release, deadzone edge
    beats_to_send.push_back(make_beat(OP_TICK, 1'b0, 1'b0, 0, 0));
    beats_to_send.push_back(make_beat(OP_SAMPLE, 1'b1, 1'b1, 32767, -32768));
    repeat (3) beats_to_send.push_back(make_beat(OP_TICK, 1'b1, 1'b1, -1, -1));
    beats_to_send.push_back(make_beat(OP_SAMPLE, 1'b1, 1'b0, 0, 0));
    beats_to_send.push_back(make_beat(OP_TICK, 1'b0, 1'b0, 0, 0));
    beats_to_send.push_back(make_beat(OP_SAMPLE, 1'b0, 1'b1, 32767, 32767));
    beats_to_send.push_back(make_beat(OP_TICK, 1'b0, 1'b0, 0, 0));
    beats_to_send.push_back(make_beat(OP_SAMPLE, 1'b1, 1'b1, 2293, -2294));
    beats_to_send.push_back(make_beat(OP_TICK, 1'b0, 1'b0, 0, 0));
    beats_to_send.push_back(make_beat(OP_SAMPLE, 1'b1, 1'b1, -32768, 32767));
    beats_to_send.push_back(make_beat(OP_TICK, 1'b0, 1'b0, 0, 0));
    beats_to_send.push_back(make_beat(OP_SAMPLE, 1'b1, 1'b1, 1, -1));
    repeat (2) beats_to_send.push_back(make_beat(OP_TICK, 1'b0, 1'b0, 0, 0));
    queue_random(PHASE_BEATS);

    for (int p = 1; p <= 9; p++) begin
      wait_quiet();
      program_phase(p);
      if (p == 9) begin
        // watchdog disabled at counter max; a long tick run keeps the targets
        beats_to_send.push_back(make_beat(OP_SAMPLE, 1'b1, 1'b1, 16384, -16384));
        repeat (LONG_TICKS) beats_to_send.push_back(rand_tick());
        queue_random(40);
      end else begin
        queue_random(PHASE_BEATS);
      end
    end

    wait_quiet();
    if (errors == 0 && cmds_expected.size() == 0)
      $display("tb_joystick_velocity_ramp OK");
    else
      $display("tb_joystick_velocity_ramp NOT OK");
    $finish;
  end

endmodule
